### design/assert_macros.svh
// Assertion macros shared by the queue, front end and back end design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define AWSP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, disabled during reset
`define AWSP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define AWSP_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define AWSP_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif
`endif

### design/awsp_pkg.sv
// Types, constants and helpers for the anemometer wind speed block
`default_nettype none
package awsp_pkg;

   localparam int TIME_W  = 32;
   localparam int DEB_W   = 8;
   localparam int SCALE_W = 16;
   localparam int COUNT_W = 16;
   localparam int SPEED_W = 20;
   localparam int CSR_DATA_W = 16;

   // Average numerator is scale * count * 100
   localparam int MULT_W = 7;
   localparam int PROD_W = SCALE_W + COUNT_W;
   localparam int NUM_W  = PROD_W + MULT_W;
   localparam int STEP_W = $clog2(NUM_W);

   localparam logic [MULT_W-1:0]  SPEED_MULT    = MULT_W'(100);
   localparam logic [COUNT_W-1:0] COUNT_MAX     = '1;
   localparam logic [SPEED_W-1:0] SPEED_MAX     = '1;
   localparam logic [DEB_W-1:0]   DEBOUNCE_RST  = DEB_W'(10);
   localparam logic [SCALE_W-1:0] SCALE_RST     = SCALE_W'(1492);
   localparam logic [TIME_W-1:0]  PERIOD_NONE   = '1;

   typedef enum logic {
      OP_EDGE    = 1'b0,
      OP_READOUT = 1'b1
   } op_type;

   typedef enum logic [0:0] {
      CSR_DEBOUNCE = 1'b0,
      CSR_SCALE    = 1'b1
   } csr_index_type;

   typedef struct packed {
      op_type            opcode;
      logic [TIME_W-1:0] time_ms;
   } req_type;

   typedef struct packed {
      logic [SPEED_W-1:0] avg_speed_centi_mph;
      logic [SPEED_W-1:0] gust_speed_centi_mph;
      logic [COUNT_W-1:0] periods_used;
   } rsp_type;

   // Snapshot of one readout window handed to the back end
   typedef struct packed {
      logic [COUNT_W-1:0] count;
      logic [TIME_W-1:0]  sum;
      logic [TIME_W-1:0]  shortest;
      logic [SCALE_W-1:0] scale;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_MUL,
      BK_LOAD_AVG,
      BK_DIV_AVG,
      BK_LOAD_GUST,
      BK_DIV_GUST,
      BK_FINISH
   } bk_state_type;

   // Clamp a quotient to the speed range; a zero divisor saturates
   function automatic logic [SPEED_W-1:0] sat_speed(logic [NUM_W-1:0] quot,
                                                   logic den_zero);
      logic [SPEED_W-1:0] res;
      if (den_zero || (|quot[NUM_W-1:SPEED_W])) begin
         res = SPEED_MAX;
      end else begin
         res = quot[SPEED_W-1:0];
      end
      return res;
   endfunction

endpackage
`default_nettype wire

### design/anemometer_period_wind_speed.sv
// Top level of the anemometer period wind speed block
// Edge transactions are taken one per cycle when the input is not stalled and
// fold their period into the window accumulators at once; they produce no
// result. A readout transaction snapshots the window into a two-entry job
// queue, and the back end turns each job into one result: a multiply stage,
// a 39-step restoring division for the average speed and a second 39-step pass
// of the same divider for the gust speed, then the output register. A readout
// of an empty window skips both divisions. The input stalls only while two
// readouts are queued; the output register lets the back end compute the next
// job while a result waits to be taken. There is no clearing pass.
`default_nettype none
module anemometer_period_wind_speed (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire awsp_pkg::req_type                    req_payload,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_stall,
   output awsp_pkg::rsp_type                         rsp_payload,
   input  wire logic                                 csr_wr_en,
   input  wire awsp_pkg::csr_index_type              csr_index,
   input  wire logic [awsp_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import awsp_pkg::*;

   logic         push;
   job_type      push_job;
   logic         pop;
   job_type      head;
   q_status_type q_status;

   awsp_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .push        (push),
      .push_job    (push_job),
      .q_status    (q_status)
   );

   awsp_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head     (head),
      .status   (q_status)
   );

   awsp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .q_status    (q_status),
      .q_head      (head),
      .q_pop       (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule
`default_nettype wire

### design/awsp_queue.sv
// Two-entry queue of readout jobs between front and back end
`default_nettype none
`include "assert_macros.svh"
module awsp_queue (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire awsp_pkg::job_type    push_job,
   input  wire logic                 pop,
   output awsp_pkg::job_type         head,
   output awsp_pkg::q_status_type    status
);
   import awsp_pkg::*;

   localparam int DEPTH = 2;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   job_type            entry_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;

   // Status and head entry
   assign status.full  = (cnt_ff == CNT_W'(DEPTH));
   assign status.empty = (cnt_ff == '0);
   assign head         = entry_ff[rd_ptr_ff];

   // Advance pointers and fill count
   always_comb begin
      wr_ptr_in = push ? PTR_W'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? PTR_W'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = CNT_W'(cnt_ff + 1'b1);
      end else if (pop && !push) begin
         cnt_in = CNT_W'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the pushed job
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `AWSP_ASSERT_IMP(a_no_push_full, clock, reset, push, !status.full || pop, "push into full queue")
   `AWSP_ASSERT_IMP(a_no_pop_empty, clock, reset, pop, !status.empty, "pop from empty queue")
   `AWSP_ASSERT_NXT(a_push_fills, clock, reset, push && !pop, !status.empty, "pushed job lost")
   `AWSP_ASSERT_IMP(a_cnt_range, clock, reset, 1'b1, cnt_ff <= CNT_W'(DEPTH), "queue overfilled")

endmodule
`default_nettype wire

### design/awsp_front.sv
// Front end: configuration, edge classification, accumulators, readout snapshots
`default_nettype none
`include "assert_macros.svh"
module awsp_front (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_stall,
   input  wire awsp_pkg::req_type                    req_payload,
   input  wire logic                                 csr_wr_en,
   input  wire awsp_pkg::csr_index_type              csr_index,
   input  wire logic [awsp_pkg::CSR_DATA_W-1:0]      csr_wr_data,
   output logic                                      push,
   output awsp_pkg::job_type                         push_job,
   input  wire awsp_pkg::q_status_type               q_status
);
   import awsp_pkg::*;

   logic [DEB_W-1:0]   debounce_ff, debounce_in;
   logic [SCALE_W-1:0] scale_ff, scale_in;
   logic               have_ff, have_in;
   logic [TIME_W-1:0]  last_ff, last_in;
   logic [TIME_W-1:0]  shortest_ff, shortest_in;
   logic [TIME_W-1:0]  sum_ff, sum_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic               accept;
   logic [TIME_W-1:0]  period;
   logic               bounce;
   logic [TIME_W:0]    sum_wide;

   // Readouts wait while the queue is full; hold everything then
   assign req_stall = q_status.full;
   assign accept    = req_valid && !req_stall;

   assign period   = req_payload.time_ms - last_ff;
   assign bounce   = have_ff && (period < TIME_W'(debounce_ff));
   assign sum_wide = {1'b0, sum_ff} + {1'b0, period};

   // Configuration writes
   always_comb begin
      debounce_in = debounce_ff;
      scale_in    = scale_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_DEBOUNCE: debounce_in = csr_wr_data[DEB_W-1:0];
            CSR_SCALE:    scale_in    = csr_wr_data[SCALE_W-1:0];
            default:      debounce_in = debounce_ff;
         endcase
      end
   end

   // Update accumulators on edges, clear them on readout
   always_comb begin
      have_in     = have_ff;
      last_in     = last_ff;
      shortest_in = shortest_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      if (accept) begin
         case (req_payload.opcode)
            OP_EDGE: begin
               if (!bounce) begin
                  if (have_ff) begin
                     if (period < shortest_ff) begin
                        shortest_in = period;
                     end
                     sum_in   = sum_wide[TIME_W] ? '1 : sum_wide[TIME_W-1:0];
                     count_in = (count_ff == COUNT_MAX) ? count_ff
                                                        : COUNT_W'(count_ff + 1'b1);
                  end
                  have_in = 1'b1;
                  last_in = req_payload.time_ms;
               end
            end
            OP_READOUT: begin
               shortest_in = PERIOD_NONE;
               sum_in      = '0;
               count_in    = '0;
            end
            default: have_in = have_ff;
         endcase
      end
   end

   // Hand the window snapshot to the queue
   assign push              = accept && (req_payload.opcode == OP_READOUT);
   assign push_job.count    = count_ff;
   assign push_job.sum      = sum_ff;
   assign push_job.shortest = shortest_ff;
   assign push_job.scale    = scale_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ff <= DEBOUNCE_RST;
         scale_ff    <= SCALE_RST;
         have_ff     <= 1'b0;
         last_ff     <= '0;
         shortest_ff <= PERIOD_NONE;
         sum_ff      <= '0;
         count_ff    <= '0;
      end else begin
         debounce_ff <= debounce_in;
         scale_ff    <= scale_in;
         have_ff     <= have_in;
         last_ff     <= last_in;
         shortest_ff <= shortest_in;
         sum_ff      <= sum_in;
         count_ff    <= count_in;
      end
   end

   `AWSP_ASSERT_IMP(a_empty_window, clock, reset, count_ff == '0, (sum_ff == '0) && (shortest_ff == PERIOD_NONE), "empty window not clean")
   `AWSP_ASSERT_NXT(a_readout_clears, clock, reset, push, count_ff == '0, "readout did not clear count")
   `AWSP_ASSERT_IMP(a_count_needs_edge, clock, reset, count_ff != '0, have_ff, "period counted before first edge")

endmodule
`default_nettype wire

### design/awsp_back.sv
// Back end: speed computation with a shared restoring divider and output register
`default_nettype none
`include "assert_macros.svh"
module awsp_back (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire awsp_pkg::q_status_type q_status,
   input  wire awsp_pkg::job_type    q_head,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output awsp_pkg::rsp_type         rsp_payload
);
   import awsp_pkg::*;

   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_W - 1);

   bk_state_type       state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_payload_ff;
   job_type            job_ff;
   logic [PROD_W-1:0]  prod_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [TIME_W-1:0]  den_ff;
   logic [TIME_W-1:0]  rem_ff;
   logic [STEP_W-1:0]  step_ff;
   logic [SPEED_W-1:0] avg_ff;

   logic               out_free;
   logic               out_load;
   logic               last_step;
   logic [TIME_W:0]    shifted;
   logic [TIME_W:0]    diff;
   logic               fits;
   logic [NUM_W-1:0]   num_in;
   logic [TIME_W-1:0]  rem_in;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign last_step = (step_ff == LAST_STEP);

   // One restoring division step: bring down a numerator bit, try the divisor
   assign shifted = {rem_ff, num_ff[NUM_W-1]};
   assign diff    = shifted - {1'b0, den_ff};
   assign fits    = (shifted >= {1'b0, den_ff});
   assign rem_in  = fits ? diff[TIME_W-1:0] : shifted[TIME_W-1:0];
   assign num_in  = {num_ff[NUM_W-2:0], fits};

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE:      if (!q_status.empty) state_in = BK_MUL;
         BK_MUL:       state_in = (job_ff.count == '0) ? BK_FINISH : BK_LOAD_AVG;
         BK_LOAD_AVG:  state_in = BK_DIV_AVG;
         BK_DIV_AVG:   if (last_step) state_in = BK_LOAD_GUST;
         BK_LOAD_GUST: state_in = BK_DIV_GUST;
         BK_DIV_GUST:  if (last_step) state_in = BK_FINISH;
         BK_FINISH:    if (out_free) state_in = BK_IDLE;
         default:      state_in = BK_IDLE;
      endcase
   end

   // Control outputs
   always_comb begin
      q_pop    = 1'b0;
      out_load = 1'b0;
      case (state_ff)
         BK_IDLE:   q_pop    = !q_status.empty;
         BK_FINISH: out_load = out_free;
         default:   q_pop    = 1'b0;
      endcase
   end

   assign rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath: multiply, divide twice unless the window is empty, then load the result register
   always_ff @(posedge clock) begin
      case (state_ff)
         BK_IDLE: begin
            if (q_pop) begin
               job_ff <= q_head;
            end
         end
         BK_MUL: begin
            prod_ff <= PROD_W'(job_ff.scale) * PROD_W'(job_ff.count);
         end
         BK_LOAD_AVG: begin
            num_ff  <= NUM_W'(prod_ff) * NUM_W'(SPEED_MULT);
            den_ff  <= job_ff.sum;
            rem_ff  <= '0;
            step_ff <= '0;
         end
         BK_DIV_AVG, BK_DIV_GUST: begin
            num_ff  <= num_in;
            rem_ff  <= rem_in;
            step_ff <= STEP_W'(step_ff + 1'b1);
         end
         BK_LOAD_GUST: begin
            avg_ff  <= sat_speed(num_ff, den_ff == '0);
            num_ff  <= NUM_W'(job_ff.scale) * NUM_W'(SPEED_MULT);
            den_ff  <= job_ff.shortest;
            rem_ff  <= '0;
            step_ff <= '0;
         end
         BK_FINISH: begin
            if (out_load) begin
               if (job_ff.count == '0) begin
                  rsp_payload_ff <= '0;
               end else begin
                  rsp_payload_ff.avg_speed_centi_mph  <= avg_ff;
                  rsp_payload_ff.gust_speed_centi_mph <= sat_speed(num_ff, den_ff == '0);
                  rsp_payload_ff.periods_used         <= job_ff.count;
               end
            end
         end
         default: begin
            step_ff <= step_ff;
         end
      endcase
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   `AWSP_ASSERT_IMP(a_zero_window, clock, reset, rsp_valid_ff && (rsp_payload_ff.periods_used == '0), (rsp_payload_ff.avg_speed_centi_mph == '0) && (rsp_payload_ff.gust_speed_centi_mph == '0), "empty window gave nonzero speed")
   `AWSP_ASSERT_NXT(a_avg_to_gust, clock, reset, (state_ff == BK_DIV_AVG) && last_step, state_ff == BK_LOAD_GUST, "average division did not hand over")
   `AWSP_ASSERT_NXT(a_load_shows, clock, reset, out_load, rsp_valid_ff, "result load lost")
   `AWSP_ASSERT_IMP(a_no_overwrite, clock, reset, out_load, !rsp_valid_ff || !rsp_stall, "pending result overwritten")

endmodule
`default_nettype wire
